### src/rss_pkg.sv
package rss_pkg;

    // Field widths of the result item
    localparam int STATUS_W   = 3;
    localparam int PAGE_OUT_W = 7;
    localparam int SLOT_OUT_W = 3;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STS_REUSED    = 3'd0;
    localparam logic [STATUS_W-1:0] STS_APPENDED  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NEW_PAGE  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_DELETED   = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] STS_FULL      = 3'd5;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_REUSE_WR,
        S_SCAN_CHK,
        S_DONE
    } t_state;

endpackage

### src/record_slot_store_with_free_list.sv
// Paged record store: each slot holds a key and a payload word, SLOTS_PER_PAGE slots to a
// page and MAX_DATA_PAGES pages, reported 1-based. An insert reuses the most recently
// freed slot (LIFO free list whose links sit in the freed slots), else appends at the
// next slot, flagging a new page on the first slot of any page but the first, else
// reports full. A delete walks the written slots in page order and frees the first live
// slot with a matching key. An item is taken only while the sequencer is idle
// (o_stall low). A delete reads the slot memories through one read address, one slot
// per cycle, examining at most SLOTS_PER_PAGE * MAX_DATA_PAGES slots. The result then
// sits in an output register, and the next item may be taken while it waits there.
// No clearing pass after reset: only data read from slots that were written is used.
module record_slot_store_with_free_list #(
    parameter int SLOTS_PER_PAGE = 8,
    parameter int MAX_DATA_PAGES = 64,
    parameter int KEY_BITS       = 48,
    parameter int PAYLOAD_BITS   = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_req_type,
    input  logic [KEY_BITS-1:0]                 i_key,
    input  logic [PAYLOAD_BITS-1:0]             i_payload,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [rss_pkg::STATUS_W-1:0]        o_status,
    output logic [rss_pkg::PAGE_OUT_W-1:0]      o_page,
    output logic [rss_pkg::SLOT_OUT_W-1:0]      o_slot
);

    localparam int SLOT_W = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;
    localparam int PAGE_W = (MAX_DATA_PAGES > 1) ? $clog2(MAX_DATA_PAGES) : 1;
    localparam int APW    = $clog2(MAX_DATA_PAGES + 1);
    localparam int ADDR_W = PAGE_W + SLOT_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int META_W = ADDR_W + 2;
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOTS_PER_PAGE - 1);
    localparam logic [APW-1:0]    PAGE_LIMIT = APW'(MAX_DATA_PAGES);

    // Slot memories; meta word is {freed, link valid, link}
    logic [KEY_BITS-1:0]     mem_key [DEPTH];
    logic [PAYLOAD_BITS-1:0] mem_pay [DEPTH];
    logic [META_W-1:0]       mem_meta [DEPTH];

    rss_pkg::t_state r_state, n_state;

    logic [KEY_BITS-1:0]     r_key, n_key;
    logic [PAYLOAD_BITS-1:0] r_pay, n_pay;
    logic [APW-1:0]          r_app_page, n_app_page;
    logic [SLOT_W-1:0]       r_app_slot, n_app_slot;
    logic [APW-1:0]          r_scan_page, n_scan_page;
    logic [SLOT_W-1:0]       r_scan_slot, n_scan_slot;
    logic                    r_free_vld, n_free_vld;
    logic [ADDR_W-1:0]       r_free_head, n_free_head;

    logic [rss_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [PAGE_W-1:0]            r_res_page, n_res_page;
    logic [SLOT_W-1:0]            r_res_slot, n_res_slot;
    logic                         r_res_none, n_res_none;

    logic                              r_out_vld;
    logic [rss_pkg::STATUS_W-1:0]      r_out_status;
    logic [rss_pkg::PAGE_OUT_W-1:0]    r_out_page;
    logic [rss_pkg::SLOT_OUT_W-1:0]    r_out_slot;

    logic [KEY_BITS-1:0] r_key_q;
    logic [META_W-1:0]   r_meta_q;

    // Memory port controls
    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       wr_addr;
    logic                    we_data;
    logic                    we_meta;
    logic [KEY_BITS-1:0]     wr_key;
    logic [PAYLOAD_BITS-1:0] wr_pay;
    logic [META_W-1:0]       wr_meta;

    // Scan stepping and positions
    logic              scan_wrap;
    logic [SLOT_W-1:0] scan_nxt_slot;
    logic [APW-1:0]    scan_nxt_page;
    logic [ADDR_W-1:0] app_addr;
    logic [ADDR_W-1:0] scan_addr;
    logic [ADDR_W-1:0] scan_nxt_addr;
    logic              scan_at_end;
    logic              key_hit;
    logic              out_free;
    logic [PAGE_W:0]   res_page_1;

    assign scan_wrap     = (r_scan_slot == LAST_SLOT);
    assign scan_nxt_slot = scan_wrap ? '0 : r_scan_slot + 1'b1;
    assign scan_nxt_page = scan_wrap ? r_scan_page + 1'b1 : r_scan_page;
    assign app_addr      = {r_app_page[PAGE_W-1:0], r_app_slot};
    assign scan_addr     = {r_scan_page[PAGE_W-1:0], r_scan_slot};
    assign scan_nxt_addr = {scan_nxt_page[PAGE_W-1:0], scan_nxt_slot};
    assign scan_at_end   = (scan_nxt_page == r_app_page) && (scan_nxt_slot == r_app_slot);
    assign key_hit       = !r_meta_q[META_W-1] && (r_key_q == r_key);
    assign out_free      = !r_out_vld || !i_stall;

    assign o_stall = (r_state != rss_pkg::S_IDLE);

    // Sequencer: next state, memory controls and result
    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_pay        = r_pay;
        n_app_page   = r_app_page;
        n_app_slot   = r_app_slot;
        n_scan_page  = r_scan_page;
        n_scan_slot  = r_scan_slot;
        n_free_vld   = r_free_vld;
        n_free_head  = r_free_head;
        n_res_status = r_res_status;
        n_res_page   = r_res_page;
        n_res_slot   = r_res_slot;
        n_res_none   = r_res_none;
        rd_addr      = r_free_head;
        wr_addr      = r_free_head;
        we_data      = 1'b0;
        we_meta      = 1'b0;
        wr_key       = r_key;
        wr_pay       = r_pay;
        wr_meta      = '0;

        unique case (r_state)
            rss_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_key = i_key;
                    n_pay = i_payload;
                    if (i_req_type == rss_pkg::REQ_INSERT) begin
                        if (r_free_vld) begin
                            // fetch the head's link, written next cycle
                            rd_addr = r_free_head;
                            n_state = rss_pkg::S_REUSE_WR;
                        end else if (r_app_page == PAGE_LIMIT) begin
                            n_res_status = rss_pkg::STS_FULL;
                            n_res_none   = 1'b1;
                            n_state      = rss_pkg::S_DONE;
                        end else begin
                            // append at the next unwritten slot
                            we_data      = 1'b1;
                            we_meta      = 1'b1;
                            wr_addr      = app_addr;
                            wr_key       = i_key;
                            wr_pay       = i_payload;
                            n_res_status = (r_app_slot == '0 && r_app_page != '0) ?
                                           rss_pkg::STS_NEW_PAGE : rss_pkg::STS_APPENDED;
                            n_res_page   = r_app_page[PAGE_W-1:0];
                            n_res_slot   = r_app_slot;
                            n_res_none   = 1'b0;
                            if (r_app_slot == LAST_SLOT) begin
                                n_app_slot = '0;
                                n_app_page = r_app_page + 1'b1;
                            end else begin
                                n_app_slot = r_app_slot + 1'b1;
                            end
                            n_state = rss_pkg::S_DONE;
                        end
                    end else begin
                        // delete: start the scan at the first slot
                        n_scan_page = '0;
                        n_scan_slot = '0;
                        rd_addr     = '0;
                        if (r_app_page == '0 && r_app_slot == '0) begin
                            n_res_status = rss_pkg::STS_NOT_FOUND;
                            n_res_none   = 1'b1;
                            n_state      = rss_pkg::S_DONE;
                        end else begin
                            n_state = rss_pkg::S_SCAN_CHK;
                        end
                    end
                end
            end
            rss_pkg::S_REUSE_WR: begin
                // pop the head, overwrite the slot
                we_data      = 1'b1;
                we_meta      = 1'b1;
                wr_addr      = r_free_head;
                n_free_vld   = r_meta_q[META_W-2];
                n_free_head  = r_meta_q[META_W-2] ? r_meta_q[ADDR_W-1:0] : '0;
                n_res_status = rss_pkg::STS_REUSED;
                n_res_page   = r_free_head[ADDR_W-1:SLOT_W];
                n_res_slot   = r_free_head[SLOT_W-1:0];
                n_res_none   = 1'b0;
                n_state      = rss_pkg::S_DONE;
            end
            rss_pkg::S_SCAN_CHK: begin
                if (key_hit) begin
                    // push the slot onto the free list
                    we_meta      = 1'b1;
                    wr_addr      = scan_addr;
                    wr_meta      = {1'b1, r_free_vld, r_free_head};
                    n_free_vld   = 1'b1;
                    n_free_head  = scan_addr;
                    n_res_status = rss_pkg::STS_DELETED;
                    n_res_page   = r_scan_page[PAGE_W-1:0];
                    n_res_slot   = r_scan_slot;
                    n_res_none   = 1'b0;
                    n_state      = rss_pkg::S_DONE;
                end else if (scan_at_end) begin
                    n_res_status = rss_pkg::STS_NOT_FOUND;
                    n_res_none   = 1'b1;
                    n_state      = rss_pkg::S_DONE;
                end else begin
                    n_scan_page = scan_nxt_page;
                    n_scan_slot = scan_nxt_slot;
                    rd_addr     = scan_nxt_addr;
                end
            end
            rss_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = rss_pkg::S_IDLE;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rss_pkg::S_IDLE;
            r_app_page  <= '0;
            r_app_slot  <= '0;
            r_free_vld  <= 1'b0;
            r_free_head <= '0;
        end else begin
            r_state     <= n_state;
            r_app_page  <= n_app_page;
            r_app_slot  <= n_app_slot;
            r_free_vld  <= n_free_vld;
            r_free_head <= n_free_head;
        end
    end

    // Item and result holding registers
    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_pay        <= n_pay;
        r_scan_page  <= n_scan_page;
        r_scan_slot  <= n_scan_slot;
        r_res_status <= n_res_status;
        r_res_page   <= n_res_page;
        r_res_slot   <= n_res_slot;
        r_res_none   <= n_res_none;
    end

    // Slot memories, registered read
    always_ff @(posedge i_clk) begin
        if (we_data) begin
            mem_key[wr_addr] <= wr_key;
            mem_pay[wr_addr] <= wr_pay;
        end
        if (we_meta) begin
            mem_meta[wr_addr] <= wr_meta;
        end
        r_key_q  <= mem_key[rd_addr];
        r_meta_q <= mem_meta[rd_addr];
    end

    // Output register
    assign res_page_1 = {1'b0, r_res_page} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == rss_pkg::S_DONE && out_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rss_pkg::S_DONE && out_free) begin
            r_out_status <= r_res_status;
            r_out_page   <= r_res_none ? '0 : rss_pkg::PAGE_OUT_W'(res_page_1);
            r_out_slot   <= r_res_none ? '0 : rss_pkg::SLOT_OUT_W'(r_res_slot);
        end
    end

    assign o_valid  = r_out_vld;
    assign o_status = r_out_status;
    assign o_page   = r_out_page;
    assign o_slot   = r_out_slot;

    // Checks
    logic [APW-1:0] head_page;
    logic           head_below_app;
    logic           scan_below_app;

    assign head_page      = APW'(r_free_head[ADDR_W-1:SLOT_W]);
    assign head_below_app = (head_page < r_app_page) ||
                            (head_page == r_app_page && r_free_head[SLOT_W-1:0] < r_app_slot);
    assign scan_below_app = (r_scan_page < r_app_page) ||
                            (r_scan_page == r_app_page && r_scan_slot < r_app_slot);

    a_head_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_vld |-> head_below_app)
        else $error("free list head points past the written slots");

    a_full_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_app_page == PAGE_LIMIT) |-> (r_app_slot == '0))
        else $error("append position beyond the last page");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rss_pkg::S_SCAN_CHK) |-> scan_below_app)
        else $error("scan reads an unwritten slot");

    a_push_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rss_pkg::S_SCAN_CHK && we_meta) |=>
            (r_free_vld && r_state == rss_pkg::S_DONE))
        else $error("delete hit did not push the free list");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == rss_pkg::S_DONE))
        else $error("result shown without a finished item");

endmodule
